### rtl/wbps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared constants and types of the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

   localparam int PATTERN_MAX = 16;
   // pattern registers hold at most 16 bytes
   localparam int PAT_LIMIT   = (PATTERN_MAX < 16) ? PATTERN_MAX : 16;
   localparam int IDX_W       = (PAT_LIMIT > 1) ? $clog2(PAT_LIMIT) : 1;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LOW  = 3'd0,
      CSR_PATTERN_HIGH = 3'd1,
      CSR_WILDCARD     = 3'd2,
      CSR_LENGTH       = 3'd3,
      CSR_BASE         = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic        found;
      logic [31:0] match_address;
   } rsp_item_type;

endpackage

### rtl/wbps_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_channels
// Valid/ready channel interfaces for byte input, results and register writes.
// ----------------------------------------------------------------------------
interface wbps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       region_end;

   modport source (output valid, output data_byte, output region_end, input ready);
   modport sink   (input valid, input data_byte, input region_end, output ready);
endinterface

interface wbps_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [31:0] match_address;

   modport source (output valid, output found, output match_address, input ready);
   modport sink   (input valid, input found, input match_address, output ready);
endinterface

interface wbps_csr_if import wbps_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/wildcard_byte_pattern_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan
// Scans a byte stream for the first match of a masked pattern of up to 16
// bytes and reports its address, or not found at the end of the region.
// Each result is registered in the result buffer and presented from its head entry.
// Throughput: one byte per cycle unless the result buffer is full; the window compare is a single stage.
// A two-entry result buffer keeps input flowing while a result waits.
// Reset (synchronous, active high) clears window, counters, buffer and
// all configuration registers.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scan import wbps_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   wbps_req_if.sink   req,
   wbps_rsp_if.source rsp,
   wbps_csr_if.sink   csr
);

   logic [63:0]  pat_lo_ff;
   logic [63:0]  pat_hi_ff;
   logic [15:0]  wild_ff;
   logic [4:0]   len_ff;
   logic [31:0]  base_ff;

   logic [7:0]   win_ff [PAT_LIMIT];
   logic [7:0]   win_in [PAT_LIMIT];
   logic [31:0]  seen_ff;
   logic [31:0]  seen_in;
   logic         reported_ff;

   logic [127:0] pat_all;
   logic [7:0]   pat_byte [PAT_LIMIT];
   logic         accept;
   logic         saturated;
   logic         hit;
   logic         match;
   logic         push;
   logic         pop;
   rsp_item_type push_item;

   logic         v0_ff, v0_in, v1_ff, v1_in;
   rsp_item_type slot0_ff, slot0_in, slot1_ff, slot1_in;

   assign accept    = req.valid && req.ready;
   assign req.ready = !v1_ff;
   assign csr.ready = 1'b1;
   assign pop       = rsp.valid && rsp.ready;

   assign pat_all = {pat_hi_ff, pat_lo_ff};

   always_comb begin
      for (int k = 0; k < PAT_LIMIT; k++) begin
         pat_byte[k] = pat_all[8*k +: 8];
      end
   end

   // shifted window including the incoming item
   always_comb begin
      win_in[0] = req.data_byte;
      for (int i = 1; i < PAT_LIMIT; i++) begin
         win_in[i] = win_ff[i-1];
      end
   end

   assign saturated = (seen_ff == 32'hFFFF_FFFF);
   assign seen_in   = saturated ? seen_ff : seen_ff + 32'd1;

   always_comb begin
      logic [4:0] idx;
      hit = 1'b1;
      idx = '0;
      for (int j = 0; j < PAT_LIMIT; j++) begin
         idx = len_ff - 5'(j) - 5'd1;
         if ((5'(j) < len_ff) && !wild_ff[j] &&
             (win_in[idx[IDX_W-1:0]] != pat_byte[j])) begin
            hit = 1'b0;
         end
      end
   end

   assign match = !reported_ff && !saturated && (len_ff != 5'd0) &&
                  (len_ff <= 5'(PAT_LIMIT)) && (seen_in >= {27'd0, len_ff}) && hit;

   assign push = accept && (match || (req.region_end && !reported_ff));

   assign push_item.found         = match;
   assign push_item.match_address = match ? (base_ff + seen_in - {27'd0, len_ff}) : 32'd0;

   // two-entry result buffer
   always_comb begin
      v0_in    = v0_ff;
      v1_in    = v1_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (pop) begin
         v0_in    = v1_ff;
         slot0_in = slot1_ff;
         v1_in    = 1'b0;
      end
      if (push) begin
         if (!v0_in) begin
            v0_in    = 1'b1;
            slot0_in = push_item;
         end else begin
            v1_in    = 1'b1;
            slot1_in = push_item;
         end
      end
   end

   assign rsp.valid         = v0_ff;
   assign rsp.found         = slot0_ff.found;
   assign rsp.match_address = slot0_ff.match_address;

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff       <= 1'b0;
         v1_ff       <= 1'b0;
         seen_ff     <= '0;
         reported_ff <= 1'b0;
         pat_lo_ff   <= '0;
         pat_hi_ff   <= '0;
         wild_ff     <= '0;
         len_ff      <= '0;
         base_ff     <= '0;
         for (int i = 0; i < PAT_LIMIT; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         if (accept) begin
            if (req.region_end) begin
               seen_ff     <= '0;
               reported_ff <= 1'b0;
               for (int i = 0; i < PAT_LIMIT; i++) begin
                  win_ff[i] <= '0;
               end
            end else begin
               seen_ff <= seen_in;
               if (match) begin
                  reported_ff <= 1'b1;
               end
               for (int i = 0; i < PAT_LIMIT; i++) begin
                  win_ff[i] <= win_in[i];
               end
            end
         end
         if (csr.valid && csr.ready) begin
            unique case (csr_index_type'(csr.index))
               CSR_PATTERN_LOW:  pat_lo_ff <= csr.data;
               CSR_PATTERN_HIGH: pat_hi_ff <= csr.data;
               CSR_WILDCARD:     wild_ff   <= csr.data[15:0];
               CSR_LENGTH:       len_ff    <= csr.data[4:0];
               CSR_BASE:         base_ff   <= csr.data[31:0];
               default: ;
            endcase
         end
      end
   end

   a_skid_needs_head: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> v0_ff)
      else $error("result skid entry held without head entry");

   a_reported_has_bytes: assert property (@(posedge clock) disable iff (reset)
      reported_ff |-> (seen_ff != 32'd0))
      else $error("match reported with empty region count");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req.region_end) |=> ((seen_ff == 32'd0) && !reported_ff))
      else $error("region end did not clear scan state");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.found) |-> (rsp.match_address == 32'd0))
      else $error("not-found item carries nonzero address");

endmodule
